// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the allocator RTL. Every macro samples on clk
// and is switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
    `ASSERT_CLK(lbl, !(cond), msg)

`endif

// File: rtl/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// Types, codes and sizes shared by the free-chain allocator modules.
// ----------------------------------------------------------------------------
package ffca_pkg;

    // Link table size and derived widths
    localparam int MAX_BLOCKS = 4096;
    localparam int ADDR_W     = $clog2(MAX_BLOCKS);
    localparam int BLK_W      = 13;
    localparam int COUNT_W    = 13;
    localparam int RES_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int STEP_W     = (ADDR_W + 1 > COUNT_W) ? ADDR_W + 1 : COUNT_W;

    localparam logic [BLK_W-1:0]   END_MARK    = '1;
    localparam logic [COUNT_W-1:0] TOTAL_RESET = 13'd4096;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_FORMAT  = 2'd2,
        MODE_NONE    = 2'd3
    } mode_e;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NOFREE = 2'd1,
        STAT_RANGE  = 2'd2
    } status_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL    = 2'd0,
        CFG_RESERVED = 2'd1
    } cfg_idx_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ALLOC_CHECK,
        ST_ALLOC_LINK,
        ST_REL_READ,
        ST_REL_LINK,
        ST_FMT_WRITE,
        ST_FINISH
    } state_e;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_ALLOC_ZERO,
        OP_ALLOC_FAIL,
        OP_START_WALK,
        OP_ALLOC_READ,
        OP_ALLOC_LAST,
        OP_ALLOC_NEXT,
        OP_REL_RANGE,
        OP_REL_EMPTY,
        OP_REL_READ,
        OP_REL_END_CUR,
        OP_REL_END_NXT,
        OP_REL_NEXT,
        OP_FMT_EMPTY,
        OP_FMT_START,
        OP_FMT_LAST,
        OP_FMT_NEXT,
        OP_MODE_NONE,
        OP_LOAD_OUT
    } dp_op_e;

    typedef struct packed {
        dp_op_e op;
    } dp_cmd_t;

    typedef struct packed {
        mode_e mode;
        logic  n_zero;
        logic  n_gt_count;
        logic  start_valid;
        logic  head_valid;
        logic  res_ge_total;
        logic  cur_valid;
        logic  last_step;
        logic  nxt_valid;
        logic  step_max;
        logic  fmt_last;
    } dp_stat_t;

endpackage

// File: rtl/ffca_if.sv
// ----------------------------------------------------------------------------
// ffca_if
// Valid/ready channels of the allocator: request, response and
// configuration write.
// ----------------------------------------------------------------------------
interface ffca_req_if;
    import ffca_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [COUNT_W-1:0] block_count;
    logic [RES_W-1:0]   start_block;

    modport source (output valid, mode, block_count, start_block, input ready);
    modport sink   (input valid, mode, block_count, start_block, output ready);
endinterface

interface ffca_rsp_if;
    import ffca_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [BLK_W-1:0]   first_block;
    logic [COUNT_W-1:0] free_count;

    modport source (output valid, status, first_block, free_count, input ready);
    modport sink   (input valid, status, first_block, free_count, output ready);
endinterface

interface ffca_cfg_if;
    import ffca_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [COUNT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/ffca_ram.sv
// ----------------------------------------------------------------------------
// ffca_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read beat
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/ffca_ctrl.sv
// ----------------------------------------------------------------------------
// ffca_ctrl
// Sequencer of the allocator: takes a request, steps the datapath through
// the chain walk or format sweep and hands the result to the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffca_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  ffca_pkg::dp_stat_t stat,
    output ffca_pkg::dp_cmd_t  cmd
);
    import ffca_pkg::*;

    state_e state_reg;
    state_e state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;

    // Hold state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the output register on finish, drop it once the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == OP_LOAD_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.mode)
                    MODE_ALLOC:
                    begin
                        if (stat.n_zero || stat.n_gt_count)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_ALLOC_CHECK;
                        end
                    end
                    MODE_RELEASE:
                    begin
                        if (!stat.start_valid || !stat.head_valid)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_REL_READ;
                        end
                    end
                    MODE_FORMAT:
                    begin
                        if (stat.res_ge_total)
                        begin
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            state_next = ST_FMT_WRITE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_ALLOC_CHECK:
            begin
                if (stat.cur_valid)
                begin
                    state_next = ST_ALLOC_LINK;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_ALLOC_LINK:
            begin
                if (stat.last_step)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_ALLOC_CHECK;
                end
            end
            ST_REL_READ:
            begin
                state_next = ST_REL_LINK;
            end
            ST_REL_LINK:
            begin
                if (!stat.nxt_valid || stat.step_max)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_REL_READ;
                end
            end
            ST_FMT_WRITE:
            begin
                if (stat.fmt_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: request ready and datapath command
    always_comb
    begin
        req_ready = 1'b0;
        cmd.op    = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op = OP_LATCH;
                end
            end
            ST_DECODE:
            begin
                case (stat.mode)
                    MODE_ALLOC:
                    begin
                        if (stat.n_zero)
                        begin
                            cmd.op = OP_ALLOC_ZERO;
                        end
                        else if (stat.n_gt_count)
                        begin
                            cmd.op = OP_ALLOC_FAIL;
                        end
                        else
                        begin
                            cmd.op = OP_START_WALK;
                        end
                    end
                    MODE_RELEASE:
                    begin
                        if (!stat.start_valid)
                        begin
                            cmd.op = OP_REL_RANGE;
                        end
                        else if (!stat.head_valid)
                        begin
                            cmd.op = OP_REL_EMPTY;
                        end
                        else
                        begin
                            cmd.op = OP_START_WALK;
                        end
                    end
                    MODE_FORMAT:
                    begin
                        if (stat.res_ge_total)
                        begin
                            cmd.op = OP_FMT_EMPTY;
                        end
                        else
                        begin
                            cmd.op = OP_FMT_START;
                        end
                    end
                    default:
                    begin
                        cmd.op = OP_MODE_NONE;
                    end
                endcase
            end
            ST_ALLOC_CHECK:
            begin
                cmd.op = stat.cur_valid ? OP_ALLOC_READ : OP_ALLOC_FAIL;
            end
            ST_ALLOC_LINK:
            begin
                cmd.op = stat.last_step ? OP_ALLOC_LAST : OP_ALLOC_NEXT;
            end
            ST_REL_READ:
            begin
                cmd.op = OP_REL_READ;
            end
            ST_REL_LINK:
            begin
                if (!stat.nxt_valid)
                begin
                    cmd.op = OP_REL_END_CUR;
                end
                else if (stat.step_max)
                begin
                    cmd.op = OP_REL_END_NXT;
                end
                else
                begin
                    cmd.op = OP_REL_NEXT;
                end
            end
            ST_FMT_WRITE:
            begin
                cmd.op = stat.fmt_last ? OP_FMT_LAST : OP_FMT_NEXT;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.op = OP_LOAD_OUT;
                end
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    // Checks
    `ASSERT_CLK(a_accept_decodes, (req_valid && req_ready) |=> (state_reg == ST_DECODE),
        "accepted request did not move to decode")
    `ASSERT_CLK(a_finish_shows, (state_reg == ST_FINISH && out_free) |=> rsp_valid,
        "finished result not presented")
    `ASSERT_NEVER(a_idle_with_load, (cmd.op == OP_LOAD_OUT) && !out_free,
        "output register overwritten before its beat was taken")

endmodule

// File: rtl/ffca_dpath.sv
// ----------------------------------------------------------------------------
// ffca_dpath
// Datapath of the allocator: configuration registers, free-list head and
// count, walk cursor, link table RAM and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffca_dpath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ffca_pkg::dp_cmd_t              cmd,
    output ffca_pkg::dp_stat_t             stat,
    input  logic [1:0]                     req_mode,
    input  logic [ffca_pkg::COUNT_W-1:0]   req_block_count,
    input  logic [ffca_pkg::RES_W-1:0]     req_start_block,
    input  logic                           cfg_we,
    input  logic [ffca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffca_pkg::COUNT_W-1:0]   cfg_data,
    output logic [1:0]                     rsp_status,
    output logic [ffca_pkg::BLK_W-1:0]     rsp_first_block,
    output logic [ffca_pkg::COUNT_W-1:0]   rsp_free_count
);
    import ffca_pkg::*;

    // Control state
    logic [COUNT_W-1:0] total_reg;
    logic [RES_W-1:0]   reserved_reg;
    logic [BLK_W-1:0]   head_reg;
    logic [BLK_W-1:0]   head_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    // Operation registers
    mode_e              mode_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [RES_W-1:0]   start_reg;
    logic [BLK_W-1:0]   cur_reg;
    logic [BLK_W-1:0]   cur_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    status_e            status_reg;
    status_e            status_next;
    logic [BLK_W-1:0]   first_reg;
    logic [BLK_W-1:0]   first_next;
    logic [1:0]         out_status_reg;
    logic [BLK_W-1:0]   out_first_reg;
    logic [COUNT_W-1:0] out_count_reg;

    // Derived values
    logic [COUNT_W-1:0] eff_total;
    logic [BLK_W:0]     cur_inc;
    logic [BLK_W-1:0]   fmt_link;
    logic [COUNT_W:0]   rel_sum;
    logic [COUNT_W-1:0] rel_count;
    logic [STEP_W-1:0]  step_inc;

    // Link table port
    logic               rd_en;
    logic [BLK_W-1:0]   rd_data;
    logic               wr_en;
    logic [BLK_W-1:0]   wr_blk;
    logic [BLK_W-1:0]   wr_data;

    ffca_ram #(
        .WIDTH (BLK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_links (
        .clk   (clk),
        .we    (wr_en),
        .waddr (ADDR_W'(wr_blk)),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (ADDR_W'(cur_reg)),
        .rdata (rd_data)
    );

    // Effective volume size and helper arithmetic
    always_comb
    begin
        eff_total = (int'(total_reg) < MAX_BLOCKS) ? total_reg : COUNT_W'(MAX_BLOCKS);
        cur_inc   = {1'b0, cur_reg} + 1'b1;
        fmt_link  = (cur_inc < {1'b0, eff_total}) ? cur_inc[BLK_W-1:0] : END_MARK;
        rel_sum   = {1'b0, count_reg} + {1'b0, n_reg};
        rel_count = (rel_sum < {1'b0, eff_total}) ? rel_sum[COUNT_W-1:0] : eff_total;
        step_inc  = step_reg + 1'b1;
    end

    // Status to the controller
    always_comb
    begin
        stat.mode         = mode_reg;
        stat.n_zero       = (n_reg == '0);
        stat.n_gt_count   = (n_reg > count_reg);
        stat.start_valid  = ({1'b0, start_reg} < eff_total);
        stat.head_valid   = (head_reg < eff_total);
        stat.res_ge_total = ({1'b0, reserved_reg} >= eff_total);
        stat.cur_valid    = (cur_reg < eff_total);
        stat.last_step    = (step_inc == STEP_W'(n_reg));
        stat.nxt_valid    = (rd_data < eff_total);
        stat.step_max     = (step_reg == STEP_W'(MAX_BLOCKS - 1));
        stat.fmt_last     = !(cur_inc < {1'b0, eff_total});
    end

    // Decode the command into register updates and link table accesses
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        step_next   = step_reg;
        status_next = status_reg;
        first_next  = first_reg;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_blk      = cur_reg;
        wr_data     = END_MARK;
        case (cmd.op)
            OP_ALLOC_ZERO:
            begin
                status_next = STAT_OK;
                first_next  = END_MARK;
            end
            OP_ALLOC_FAIL:
            begin
                status_next = STAT_NOFREE;
                first_next  = END_MARK;
            end
            OP_START_WALK:
            begin
                cur_next  = head_reg;
                step_next = '0;
            end
            OP_ALLOC_READ:
            begin
                rd_en = 1'b1;
            end
            OP_ALLOC_LAST:
            begin
                // Cut the chain after the last block and move the head past it
                wr_en       = 1'b1;
                wr_data     = END_MARK;
                first_next  = head_reg;
                head_next   = rd_data;
                count_next  = count_reg - n_reg;
                status_next = STAT_OK;
            end
            OP_ALLOC_NEXT:
            begin
                cur_next  = rd_data;
                step_next = step_inc;
            end
            OP_REL_RANGE:
            begin
                status_next = STAT_RANGE;
                first_next  = head_reg;
            end
            OP_REL_EMPTY:
            begin
                head_next   = {1'b0, start_reg};
                count_next  = rel_count;
                first_next  = {1'b0, start_reg};
                status_next = STAT_OK;
            end
            OP_REL_READ:
            begin
                rd_en = 1'b1;
            end
            OP_REL_END_CUR:
            begin
                // Tail found: append the released chain after it
                wr_en       = 1'b1;
                wr_data     = {1'b0, start_reg};
                count_next  = rel_count;
                first_next  = head_reg;
                status_next = STAT_OK;
            end
            OP_REL_END_NXT:
            begin
                // Walk limit reached: append after the block just stepped to
                wr_en       = 1'b1;
                wr_blk      = rd_data;
                wr_data     = {1'b0, start_reg};
                count_next  = rel_count;
                first_next  = head_reg;
                status_next = STAT_OK;
            end
            OP_REL_NEXT:
            begin
                cur_next  = rd_data;
                step_next = step_inc;
            end
            OP_FMT_EMPTY:
            begin
                head_next   = END_MARK;
                count_next  = '0;
                first_next  = END_MARK;
                status_next = STAT_OK;
            end
            OP_FMT_START:
            begin
                cur_next = {1'b0, reserved_reg};
            end
            OP_FMT_LAST:
            begin
                wr_en       = 1'b1;
                wr_data     = fmt_link;
                head_next   = {1'b0, reserved_reg};
                count_next  = eff_total - {1'b0, reserved_reg};
                first_next  = {1'b0, reserved_reg};
                status_next = STAT_OK;
            end
            OP_FMT_NEXT:
            begin
                wr_en    = 1'b1;
                wr_data  = fmt_link;
                cur_next = cur_inc[BLK_W-1:0];
            end
            OP_MODE_NONE:
            begin
                status_next = STAT_OK;
                first_next  = head_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Hold configuration, free-list head and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= TOTAL_RESET;
            reserved_reg <= '0;
            head_reg     <= END_MARK;
            count_reg    <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cfg_we)
            begin
                case (cfg_idx_e'(cfg_index))
                    CFG_TOTAL:    total_reg    <= cfg_data;
                    CFG_RESERVED: reserved_reg <= cfg_data[RES_W-1:0];
                    default:      total_reg    <= total_reg;
                endcase
            end
        end
    end

    // Advance operation and output payload registers
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        step_reg   <= step_next;
        status_reg <= status_next;
        first_reg  <= first_next;
        if (cmd.op == OP_LATCH)
        begin
            mode_reg  <= mode_e'(req_mode);
            n_reg     <= req_block_count;
            start_reg <= req_start_block;
        end
        if (cmd.op == OP_LOAD_OUT)
        begin
            out_status_reg <= status_reg;
            out_first_reg  <= first_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign rsp_status      = out_status_reg;
    assign rsp_first_block = out_first_reg;
    assign rsp_free_count  = out_count_reg;

    // Checks
    `ASSERT_CLK(a_write_in_volume, wr_en |-> (wr_blk < eff_total),
        "link write outside the volume")
    `ASSERT_CLK(a_alloc_covered, (cmd.op == OP_ALLOC_LAST) |-> (n_reg <= count_reg),
        "allocation larger than the free count")

endmodule

// File: rtl/fat_free_chain_allocator.sv
// ----------------------------------------------------------------------------
// fat_free_chain_allocator
// FAT-style block allocator keeping its free blocks on one linked chain.
// ----------------------------------------------------------------------------
// One request is in work at a time; its result waits in an output register
// while the next request is taken. An allocate of n blocks does one link read
// and one check per block; an allocate refused by the free count or of zero
// blocks goes straight from decode to finish, and one whose chain runs short
// ends at the first bad block. A release walks the free chain to its tail and
// goes straight to finish when the start block is out of range or the free
// list is empty. Format writes one link per cycle and goes straight to finish
// when nothing is left to format; so does the idle mode. The next request is
// taken in the cycle after the result is loaded, and the finish step holds
// while a previous result still waits to be taken. The link table is a single
// RAM with one read and one write port and a registered read. It is not
// cleared after reset: run a format before the first allocate or release.
// Configuration writes are always taken and must only be made while no
// request is outstanding.
// ----------------------------------------------------------------------------
module fat_free_chain_allocator (
    input logic      clk,
    input logic      rst_n,
    ffca_req_if.sink req,
    ffca_rsp_if.source rsp,
    ffca_cfg_if.sink cfg
);
    import ffca_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration writes never stall
    assign cfg.ready = 1'b1;

    ffca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffca_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_mode        (req.mode),
        .req_block_count (req.block_count),
        .req_start_block (req.start_block),
        .cfg_we          (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .rsp_status      (rsp.status),
        .rsp_first_block (rsp.first_block),
        .rsp_free_count  (rsp.free_count)
    );

endmodule
